>>> design/des_pkg.sv
// ----------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and the round helper functions shared by the
// DES datapath.
// ----------------------------------------------------------------------------
package des_pkg;

    typedef logic [63:0] t_block;
    typedef logic [47:0] t_subkey;

    localparam int NUM_ROUNDS = 16;

    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Total left rotation of C and D after each round (running sum of 1,1,2,2,...)
    localparam logic [4:0] ROT_SUM [16] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    // Indexed by {row[1], row[0], col[3:0]}
    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    // Table entries count input bits from 1 at the top.
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63 - i] = v[64 - int'(IP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63 - i] = v[64 - int'(FP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_e(input logic [31:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47 - i] = v[32 - int'(E_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [31:0] perm_p(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[31 - i] = v[32 - int'(P_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) begin
            r[55 - i] = v[64 - int'(PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47 - i] = v[56 - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] x, input logic [4:0] n);
        return (x << n) | (x >> (5'd28 - n));
    endfunction

    // Round key k (0 based) straight from the key: wiring only.
    function automatic t_subkey round_key(input t_block key, input int k);
        logic [55:0] cd;
        cd = perm_pc1(key);
        return perm_pc2({rot28(cd[55:28], ROT_SUM[k]), rot28(cd[27:0], ROT_SUM[k])});
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] half, input t_subkey k);
        logic [47:0] x;
        logic [5:0]  b;
        logic [31:0] s;
        x = perm_e(half) ^ k;
        for (int i = 0; i < 8; i++) begin
            b = x[47 - 6 * i -: 6];
            s[31 - 4 * i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
        end
        return perm_p(s);
    endfunction

endpackage

>>> design/des_block_cipher.sv
// ----------------------------------------------------------------------------
// DES block cipher
// Fully pipelined DES: one 64-bit block per clock, one Feistel round per stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_data_block and i_mode (0 encrypt, 1 decrypt) and
//   raise i_start. A word is taken at every rising edge with i_start high
//   and o_busy low. o_busy stays low: the pipeline never stalls.
//   Result channel: o_out_valid strobes for one cycle with o_out_block. The
//   receiver cannot hold results off, so nothing waits inside the block.
//   Key channel: i_cfg_valid/o_cfg_ready load i_des_key (o_cfg_ready is
//   always high). Change the key only while no block is in flight: the
//   round keys are wired straight off the key register.
// Pipeline and throughput:
//   One input stage (initial permutation), sixteen round stages (one
//   f function each) and one output stage (swap and final permutation).
//   One block per cycle, sustained, back to back.
// Reset:
//   Synchronous, active low. Clears the key to zero and every valid bit;
//   blocks in flight are dropped.
// ----------------------------------------------------------------------------
module des_block_cipher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  des_pkg::t_block  i_data_block,
    input  logic             i_mode,
    output logic             o_out_valid,
    output des_pkg::t_block  o_out_block,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  des_pkg::t_block  i_des_key
);
    import des_pkg::*;

    localparam int LATENCY = NUM_ROUNDS + 2;

    // Key register and the round keys that hang off it
    t_block   r_key;
    t_subkey  w_subkey [NUM_ROUNDS];

    // Pipeline: stage 0 holds the block after IP, stage k after round k
    logic [31:0]         r_l    [NUM_ROUNDS + 1];
    logic [31:0]         r_r    [NUM_ROUNDS + 1];
    logic                r_mode [NUM_ROUNDS + 1];
    logic [NUM_ROUNDS:0] r_vld;

    // Round outputs feeding the next stage
    t_subkey      n_key [1:NUM_ROUNDS];
    logic [31:0]  n_r   [1:NUM_ROUNDS];

    t_block  r_out;
    logic    r_out_vld;
    logic    w_accept;
    t_block  w_ip;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_ip        = perm_ip(i_data_block);

    always_comb begin
        for (int k = 0; k < NUM_ROUNDS; k++) begin
            w_subkey[k] = round_key(r_key, k);
        end
    end

    // Round k uses key k-1 when encrypting and key 16-k when decrypting
    always_comb begin
        for (int k = 1; k <= NUM_ROUNDS; k++) begin
            n_key[k] = r_mode[k - 1] ? w_subkey[NUM_ROUNDS - k] : w_subkey[k - 1];
            n_r[k]   = r_l[k - 1] ^ feistel(r_r[k - 1], n_key[k]);
        end
    end

    // Control: valid bits and the key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_key     <= '0;
        end else begin
            r_vld     <= {r_vld[NUM_ROUNDS - 1:0], w_accept};
            r_out_vld <= r_vld[NUM_ROUNDS];
            if (i_cfg_valid && o_cfg_ready) begin
                r_key <= i_des_key;
            end
        end
    end

    // Datapath: advance every cycle, valid bits mark live words
    always_ff @(posedge i_clk) begin
        r_l[0]    <= w_ip[63:32];
        r_r[0]    <= w_ip[31:0];
        r_mode[0] <= i_mode;
        for (int k = 1; k <= NUM_ROUNDS; k++) begin
            r_l[k]    <= r_r[k - 1];
            r_r[k]    <= n_r[k];
            r_mode[k] <= r_mode[k - 1];
        end
        // Undo the last swap, then apply the inverse permutation
        r_out <= perm_fp({r_r[NUM_ROUNDS], r_l[NUM_ROUNDS]});
    end

    assign o_out_valid = r_out_vld;
    assign o_out_block = r_out;

    // A strobe only follows an accepted word by the full latency
    a_out_follows_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching accepted word");

    // The mode bit arrives at the last round stage with its own block
    a_mode_travels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_ROUNDS] |-> (r_mode[NUM_ROUNDS] == $past(i_mode, NUM_ROUNDS + 1)))
        else $error("mode bit out of step with its block");

    // A word in the last round stage always becomes a strobe next cycle
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_ROUNDS] |=> o_out_valid)
        else $error("block dropped at the output stage");

endmodule
